### hdl/pres_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pres_pkg;

   localparam int MAX_NODES_DEF = 1024;

   localparam int IDX_W   = 10;
   localparam int CNT_W   = 12;
   localparam int NCFG_W  = 11;
   localparam int DAMP_W  = 16;
   localparam int WGT_W   = 17;
   localparam int RANK_W  = 32;
   localparam int FLOW_W  = 17;
   localparam int QUO_W   = 17;

   localparam int DIV_STEPS = QUO_W;

   localparam logic [DAMP_W-1:0] DAMPING_RESET    = 16'd55706;
   localparam logic [NCFG_W-1:0] NODE_COUNT_RESET = 11'd1;
   localparam logic [RANK_W-1:0] RANK_START       = 32'd655360;
   localparam logic [QUO_W-1:0]  ONE_Q16          = 17'h10000;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_END   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_RANK  = 2'd0,
      KIND_DIFF  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_DAMPING    = 1'b0,
      CSR_NODE_COUNT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_FILL,
      S_EDGE_MUL,
      S_EDGE_WR,
      S_END,
      S_READ,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

### hdl/pagerank_edge_stream_engine.sv
// PageRank edge-stream engine, two rank banks of unsigned Q16.16 in block RAM.
// Request channel (req_valid / req_stall): one word per command. Start fills the
// current bank with 10.0 and the next bank with (1 - damping) / N; edge adds
// damping * weight * rank[src] into next[dst]; end swaps banks and reports the
// summed |old - new|; read returns one current rank.
// Response channel (rsp_valid / rsp_stall): one word per end, read, or index
// error; start and valid edges return nothing.
// Steps per command: edge reads both banks, multiplies, then writes the sum
// back into the next bank; read fetches the current rank; start runs a 17-step
// divider, then one fill write per node; end walks one node per cycle through
// both banks. N is node_count clamped to 1..MAX_NODES.
// Commands are taken one at a time: req_stall stays high until the current
// command is finished and any response is loaded into the output register.
// A held rsp_stall keeps the response word stable and holds the engine in its
// emit step. Reset clears the control registers (damping 0.85, node_count 1,
// bank zero current); banks are empty until start fills them. Users must write
// configuration (csr_write/csr_index/csr_data) while idle; nothing checks it.
`timescale 1ns / 1ps
`default_nettype none

module pagerank_edge_stream_engine
   import pres_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic [0:0]          csr_index,
   input  wire logic [DAMP_W-1:0]   csr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [IDX_W-1:0]    req_src_node,
   input  wire logic [IDX_W-1:0]    req_dst_node,
   input  wire logic [WGT_W-1:0]    req_edge_weight,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [RANK_W-1:0]        rsp_value
);

   localparam int AW = $clog2(MAX_NODES);

   // control registers
   state_type            state_ff, state_in;
   logic                 cur_bank_ff, cur_bank_in;
   logic [RANK_W-1:0]    share_ff, share_in;
   logic [DAMP_W-1:0]    damping_ff, damping_in;
   logic [NCFG_W-1:0]    node_count_ff, node_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rd_vld_ff, rd_vld_in;

   // payload registers
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [4:0]           div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [FLOW_W-1:0]    f_ff, f_in;
   logic [RANK_W-1:0]    flow_ff, flow_in;
   logic [RANK_W-1:0]    nxt_ff, nxt_in;
   logic [AW-1:0]        dst_ff, dst_in;
   logic [RANK_W-1:0]    diff_ff, diff_in;
   logic [1:0]           pend_kind_ff, pend_kind_in;
   logic [RANK_W-1:0]    pend_value_ff, pend_value_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic [RANK_W-1:0]    rsp_value_ff, rsp_value_in;

   // rank banks
   logic [RANK_W-1:0]    bank0_ff [MAX_NODES];
   logic [RANK_W-1:0]    bank1_ff [MAX_NODES];
   logic [RANK_W-1:0]    rd0_ff, rd1_ff;
   logic                 we0, we1;
   logic [AW-1:0]        wa0, wa1, ra0, ra1;
   logic [RANK_W-1:0]    wd0, wd1;

   // datapath
   logic [CNT_W-1:0]     n_live;
   logic [AW-1:0]        src_a, dst_a, cnt_a;
   logic [32:0]          fprod;
   logic [48:0]          flow_prod;
   logic [RANK_W-1:0]    cur_rd, nxt_rd, absd;
   logic [RANK_W:0]      edge_sum, diff_sum;
   logic [CNT_W:0]       div_shift;
   logic                 div_bit;
   logic                 slot_free;
   logic                 src_bad, dst_bad;

   always_comb begin
      if (node_count_ff == '0) begin
         n_live = CNT_W'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n_live = CNT_W'(MAX_NODES);
      end else begin
         n_live = CNT_W'(node_count_ff);
      end
   end

   assign src_a     = AW'(req_src_node);
   assign dst_a     = AW'(req_dst_node);
   assign cnt_a     = AW'(cnt_ff);
   assign src_bad   = CNT_W'(req_src_node) >= n_live;
   assign dst_bad   = CNT_W'(req_dst_node) >= n_live;
   assign fprod     = 33'(damping_ff) * 33'(req_edge_weight);
   assign cur_rd    = cur_bank_ff ? rd1_ff : rd0_ff;
   assign nxt_rd    = cur_bank_ff ? rd0_ff : rd1_ff;
   assign flow_prod = 49'(f_ff) * 49'(cur_rd);
   assign edge_sum  = {1'b0, nxt_ff} + {1'b0, flow_ff};
   assign absd      = (rd0_ff > rd1_ff) ? (rd0_ff - rd1_ff) : (rd1_ff - rd0_ff);
   assign diff_sum  = {1'b0, diff_ff} + {1'b0, absd};
   assign div_shift = {rem_ff, quo_ff[QUO_W-1]};
   assign div_bit   = div_shift >= {1'b0, n_live};
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cur_bank_in   = cur_bank_ff;
      share_in      = share_ff;
      damping_in    = damping_ff;
      node_count_in = node_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rd_vld_in     = 1'b0;
      cnt_in        = cnt_ff;
      div_cnt_in    = div_cnt_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      f_in          = f_ff;
      flow_in       = flow_ff;
      nxt_in        = nxt_ff;
      dst_in        = dst_ff;
      diff_in       = diff_ff;
      pend_kind_in  = pend_kind_ff;
      pend_value_in = pend_value_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      we0           = 1'b0;
      we1           = 1'b0;
      wa0           = cnt_a;
      wa1           = cnt_a;
      wd0           = share_ff;
      wd1           = share_ff;
      ra0           = cur_bank_ff ? dst_a : src_a;
      ra1           = cur_bank_ff ? src_a : dst_a;
      req_stall     = 1'b1;

      if (csr_write) begin
         case (csr_type'(csr_index))
            CSR_DAMPING:    damping_in = csr_data;
            CSR_NODE_COUNT: node_count_in = csr_data[NCFG_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (cmd_type'(req_cmd))
                  CMD_START: begin
                     cur_bank_in = 1'b0;
                     rem_in      = '0;
                     quo_in      = ONE_Q16 - QUO_W'(damping_ff);
                     div_cnt_in  = '0;
                     state_in    = S_DIV;
                  end
                  CMD_EDGE: begin
                     if (src_bad || dst_bad) begin
                        pend_kind_in  = KIND_ERROR;
                        pend_value_in = '0;
                        state_in      = S_EMIT;
                     end else begin
                        f_in     = fprod[32:16];
                        dst_in   = dst_a;
                        state_in = S_EDGE_MUL;
                     end
                  end
                  CMD_END: begin
                     cur_bank_in = !cur_bank_ff;
                     cnt_in      = '0;
                     diff_in     = '0;
                     state_in    = S_END;
                  end
                  CMD_READ: begin
                     if (src_bad) begin
                        pend_kind_in  = KIND_ERROR;
                        pend_value_in = '0;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            rem_in     = div_bit ? CNT_W'(div_shift - {1'b0, n_live}) : CNT_W'(div_shift);
            quo_in     = {quo_ff[QUO_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
               share_in = RANK_W'(quo_in);
               cnt_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (cnt_ff < n_live) begin
               we0    = 1'b1;
               we1    = 1'b1;
               wd0    = RANK_START;
               wd1    = share_ff;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EDGE_MUL: begin
            flow_in  = flow_prod[48] ? '1 : flow_prod[47:16];
            nxt_in   = nxt_rd;
            state_in = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            we0      = cur_bank_ff;
            we1      = !cur_bank_ff;
            wa0      = dst_ff;
            wa1      = dst_ff;
            wd0      = edge_sum[RANK_W] ? '1 : edge_sum[RANK_W-1:0];
            wd1      = wd0;
            state_in = S_IDLE;
         end
         S_END: begin
            ra0 = cnt_a;
            ra1 = cnt_a;
            if (rd_vld_ff) begin
               diff_in = diff_sum[RANK_W] ? '1 : diff_sum[RANK_W-1:0];
            end
            if (cnt_ff < n_live) begin
               // refill the new next bank while its old value is read out
               we0       = cur_bank_ff;
               we1       = !cur_bank_ff;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               pend_kind_in  = KIND_DIFF;
               pend_value_in = diff_ff;
               state_in      = S_EMIT;
            end
         end
         S_READ: begin
            pend_kind_in  = KIND_RANK;
            pend_value_in = cur_rd;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_value_in = pend_value_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_bank_ff   <= 1'b0;
         share_ff      <= '0;
         damping_ff    <= DAMPING_RESET;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_bank_ff   <= cur_bank_in;
         share_ff      <= share_in;
         damping_ff    <= damping_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      div_cnt_ff    <= div_cnt_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      f_ff          <= f_in;
      flow_ff       <= flow_in;
      nxt_ff        <= nxt_in;
      dst_ff        <= dst_in;
      diff_ff       <= diff_in;
      pend_kind_ff  <= pend_kind_in;
      pend_value_ff <= pend_value_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_ff[wa0] <= wd0;
      end
      rd0_ff <= bank0_ff[ra0];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1_ff[wa1] <= wd1;
      end
      rd1_ff <= bank1_ff[ra1];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;

endmodule

`default_nettype wire
